FILE: rtl/bttip_pkg.sv
// bttip_pkg: shared types, constants and codes of the text to image packer
// depends on nothing; used by the interfaces, the step logic, the result queue and the top level
`timescale 1ns / 1ps

package bttip_pkg;

	localparam int MAX_LINE      = 256;
	localparam int IMAGE_MAX     = 4096;
	localparam int LIMIT_SMALL   = 1024;
	localparam int SIZE_SAT      = 8191;
	localparam int MAX_RESULTS   = 5;
	localparam int QUEUE_DEPTH   = 8;
	localparam int LINE_COUNT_W  = $clog2(MAX_LINE);
	localparam int RES_COUNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int PTR_W         = $clog2(QUEUE_DEPTH);
	localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W        = 12;
	localparam int BASE_W        = 13;
	localparam int WIDE_W        = 14;

	// character codes
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_NUMBER = 2'd1;
	localparam logic [1:0] ST_OVER_LIMIT = 2'd2;
	localparam logic [1:0] ST_TOO_LONG   = 2'd3;

	typedef enum logic [2:0] {
		PH_START,
		PH_NUMBER,
		PH_SKIP,
		PH_BODY,
		PH_HALT
	} phase_t;

	typedef struct packed {
		phase_t                    phase;
		logic [15:0]               line_number;
		logic                      nonzero_digit_seen;
		logic [7:0]                body_length;
		logic [BASE_W-1:0]         record_base;
		logic [LINE_COUNT_W-1:0]   line_count;
	} state_t;

	typedef struct packed {
		logic              write_valid;
		logic [ADDR_W-1:0] write_address;
		logic [7:0]        write_data;
		logic              done_res;
		logic [1:0]        status;
		logic [BASE_W-1:0] image_size;
		logic              last_result;
	} result_t;

	typedef struct packed {
		logic              has_space;
		logic [FILL_W-1:0] fill;
	} rq_stat_t;

endpackage

FILE: rtl/bttip_if.sv
// bttip_if: valid/ready channel interfaces for text requests and image write results
// depends on bttip_pkg
`timescale 1ns / 1ps

interface bttip_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bttip_result_if;
	logic                             valid;
	logic                             ready;
	logic                             write_valid;
	logic [bttip_pkg::ADDR_W-1:0]     write_address;
	logic [7:0]                       write_data;
	logic                             done_res;
	logic [1:0]                       status;
	logic [bttip_pkg::BASE_W-1:0]     image_size;
	logic                             last_result;

	modport source (output valid, output write_valid, output write_address,
		output write_data, output done_res, output status, output image_size,
		output last_result, input ready);
	modport sink (input valid, input write_valid, input write_address,
		input write_data, input done_res, input status, input image_size,
		input last_result, output ready);
endinterface

FILE: rtl/bttip_step.sv
// bttip_step: per-byte decode, next state and the burst of up to five results
// depends on bttip_pkg
`timescale 1ns / 1ps

module bttip_step (
	input  bttip_pkg::state_t                     st,
	input  logic                                  limit_select,
	input  logic [7:0]                            text_byte,
	input  logic                                  end_of_text,
	output bttip_pkg::state_t                     nxt,
	output bttip_pkg::result_t                    res [bttip_pkg::MAX_RESULTS],
	output logic [bttip_pkg::RES_COUNT_W-1:0]     res_count
);

	localparam int N = bttip_pkg::MAX_RESULTS;
	localparam int W = bttip_pkg::WIDE_W;

	logic is_eol, is_digit, is_space, halted, num_zero, too_long;
	logic fail_bad, fail_long, do_close, final_rep, body_wr, rep;
	logic [W-1:0] limit, base_w, len_w, nb, rep_size_w;
	logic [bttip_pkg::BASE_W-1:0] nb_sat, rep_size;
	logic [1:0] rep_status;
	logic pad;
	logic [7:0] digit_val;
	logic [15:0] ln_next;
	logic [W-1:0] wr_addr [N];
	logic [7:0] wr_data [N];
	logic wr_en [N];
	logic [N-1:0] kept;
	logic [bttip_pkg::RES_COUNT_W-1:0] n_wr;

	// decode
	always_comb begin
		is_eol    = (text_byte == bttip_pkg::CH_CR) || (text_byte == bttip_pkg::CH_LF);
		is_digit  = (text_byte >= bttip_pkg::CH_ZERO) && (text_byte <= bttip_pkg::CH_NINE);
		is_space  = text_byte == bttip_pkg::CH_SPACE;
		halted    = st.phase == bttip_pkg::PH_HALT;
		num_zero  = (st.phase == bttip_pkg::PH_NUMBER) && !st.nonzero_digit_seen;
		too_long  = st.line_count >= bttip_pkg::LINE_COUNT_W'(bttip_pkg::MAX_LINE - 1);
		fail_bad  = !halted && (
			(end_of_text && num_zero) ||
			(!end_of_text && (st.phase == bttip_pkg::PH_START) && !is_eol && !is_digit) ||
			(!end_of_text && (st.phase != bttip_pkg::PH_START) && is_eol && num_zero) ||
			(!end_of_text && !is_eol && !too_long && num_zero && !is_digit));
		fail_long = !halted && !end_of_text && (st.phase != bttip_pkg::PH_START) &&
			!is_eol && too_long;
		do_close  = !halted && (st.phase != bttip_pkg::PH_START) &&
			(end_of_text || is_eol) && !num_zero;
		final_rep = !halted && end_of_text && !num_zero;
		body_wr   = !halted && !end_of_text && (st.phase == bttip_pkg::PH_BODY) &&
			!is_eol && !too_long;
		rep       = fail_bad || fail_long || final_rep;

		digit_val = text_byte - bttip_pkg::CH_ZERO;
		ln_next   = {st.line_number[12:0], 3'b000} + {st.line_number[14:0], 1'b0} +
			{8'd0, digit_val};

		limit  = limit_select ? W'(bttip_pkg::IMAGE_MAX) : W'(bttip_pkg::LIMIT_SMALL);
		base_w = {1'b0, st.record_base};
		len_w  = {6'd0, st.body_length};
		pad    = st.body_length[0];
		nb     = base_w + W'(4) + len_w + {13'd0, pad};
		nb_sat = (nb > W'(bttip_pkg::SIZE_SAT)) ? bttip_pkg::BASE_W'(bttip_pkg::SIZE_SAT)
			: nb[bttip_pkg::BASE_W-1:0];
	end

	// next state
	always_comb begin
		nxt = st;
		if (halted) begin
			nxt = st;
		end else if (fail_bad || fail_long) begin
			nxt.phase = bttip_pkg::PH_HALT;
		end else if (end_of_text) begin
			if (do_close)
				nxt.record_base = nb_sat;
			nxt.phase = bttip_pkg::PH_HALT;
		end else begin
			unique case (st.phase)
				bttip_pkg::PH_START: begin
					if (!is_eol) begin
						nxt.line_number        = {8'd0, digit_val};
						nxt.nonzero_digit_seen = text_byte != bttip_pkg::CH_ZERO;
						nxt.line_count         = bttip_pkg::LINE_COUNT_W'(1);
						nxt.body_length        = 8'd0;
						nxt.phase              = bttip_pkg::PH_NUMBER;
					end
				end
				bttip_pkg::PH_NUMBER, bttip_pkg::PH_SKIP, bttip_pkg::PH_BODY: begin
					if (is_eol) begin
						nxt.record_base = nb_sat;
						nxt.phase       = bttip_pkg::PH_START;
					end else begin
						nxt.line_count = st.line_count + bttip_pkg::LINE_COUNT_W'(1);
						if (st.phase == bttip_pkg::PH_NUMBER) begin
							if (is_digit) begin
								nxt.line_number = ln_next;
								if (text_byte != bttip_pkg::CH_ZERO)
									nxt.nonzero_digit_seen = 1'b1;
							end else begin
								nxt.phase = is_space ? bttip_pkg::PH_BODY : bttip_pkg::PH_SKIP;
							end
						end else if (st.phase == bttip_pkg::PH_SKIP) begin
							if (is_space)
								nxt.phase = bttip_pkg::PH_BODY;
						end else begin
							nxt.body_length = st.body_length + 8'd1;
						end
					end
				end
				default: nxt = st;
			endcase
		end
	end

	// results
	always_comb begin
		for (int j = 0; j < N; j++) begin
			wr_en[j]   = 1'b0;
			wr_addr[j] = '0;
			wr_data[j] = '0;
		end
		if (do_close) begin
			wr_en[0] = 1'b1; wr_addr[0] = base_w;
			wr_data[0] = st.line_number[7:0];
			wr_en[1] = 1'b1; wr_addr[1] = base_w + W'(1);
			wr_data[1] = st.line_number[15:8];
			wr_en[2] = 1'b1; wr_addr[2] = base_w + W'(2);
			wr_data[2] = st.body_length + {7'd0, pad};
			wr_en[3] = 1'b1; wr_addr[3] = base_w + W'(3) + len_w;
			wr_en[4] = pad;  wr_addr[4] = base_w + W'(4) + len_w;
		end else if (body_wr) begin
			wr_en[0] = 1'b1; wr_addr[0] = base_w + W'(3) + len_w;
			wr_data[0] = text_byte;
		end

		rep_size_w = do_close ? {1'b0, nb_sat} : base_w;
		rep_size   = rep_size_w[bttip_pkg::BASE_W-1:0];
		if (fail_bad)
			rep_status = bttip_pkg::ST_BAD_NUMBER;
		else if (fail_long)
			rep_status = bttip_pkg::ST_TOO_LONG;
		else if (rep_size_w > limit)
			rep_status = bttip_pkg::ST_OVER_LIMIT;
		else
			rep_status = bttip_pkg::ST_OK;

		// addresses rise within a burst, so suppressed writes form a tail
		n_wr = '0;
		for (int j = 0; j < N; j++) begin
			kept[j] = wr_en[j] && (wr_addr[j] < limit);
			n_wr = n_wr + bttip_pkg::RES_COUNT_W'(kept[j]);
		end
		res_count = (rep && (n_wr == '0)) ? bttip_pkg::RES_COUNT_W'(1) : n_wr;

		for (int j = 0; j < N; j++) begin
			res[j] = '0;
			if (kept[j]) begin
				res[j].write_valid   = 1'b1;
				res[j].write_address = wr_addr[j][bttip_pkg::ADDR_W-1:0];
				res[j].write_data    = wr_data[j];
			end
			if (bttip_pkg::RES_COUNT_W'(j + 1) == res_count) begin
				res[j].last_result = 1'b1;
				if (rep) begin
					res[j].done_res   = 1'b1;
					res[j].status     = rep_status;
					res[j].image_size = rep_size;
				end
			end
		end
	end

endmodule

FILE: rtl/bttip_rq.sv
// bttip_rq: small result queue, takes a burst of up to five results a cycle, gives one
// depends on bttip_pkg
`timescale 1ns / 1ps

module bttip_rq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bttip_pkg::result_t                   push_data [bttip_pkg::MAX_RESULTS],
	input  logic [bttip_pkg::RES_COUNT_W-1:0]    push_count,
	input  logic                                 pop,
	output bttip_pkg::result_t                   head,
	output logic                                 head_valid,
	output bttip_pkg::rq_stat_t                  stat
);

	bttip_pkg::result_t mem [bttip_pkg::QUEUE_DEPTH];
	logic [bttip_pkg::PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [bttip_pkg::FILL_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		for (int j = 0; j < bttip_pkg::MAX_RESULTS; j++) begin
			if (bttip_pkg::RES_COUNT_W'(j) < push_count)
				mem[wr_ptr_q + bttip_pkg::PTR_W'(j)] <= push_data[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + bttip_pkg::PTR_W'(push_count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + bttip_pkg::PTR_W'(1);
			fill_q <= fill_q + bttip_pkg::FILL_W'(push_count) - bttip_pkg::FILL_W'(pop);
		end
	end

	assign head           = mem[rd_ptr_q];
	assign head_valid     = fill_q != '0;
	assign stat.fill      = fill_q;
	assign stat.has_space = fill_q <=
		bttip_pkg::FILL_W'(bttip_pkg::QUEUE_DEPTH - bttip_pkg::MAX_RESULTS);

endmodule

FILE: rtl/basic_text_to_image_packer_core.sv
// basic_text_to_image_packer_core: top level of the text to image packer
// depends on bttip_pkg, bttip_if, bttip_step and bttip_rq
//
//   channel     | kind      | carries
//   ------------+-----------+------------------------------------------------------
//   text        | sink      | text_byte, end_of_text: one character request a beat
//   result      | source    | image byte write and/or final report, last_result flag
//   cfg_wen/    | write     | limit_select: 0 gives a 1024 byte image, 1 gives 4096
//   cfg_wdata   |           |
//
// one text request a cycle, sustained while the result queue has room; a request passes
// through the input register, then the result queue, before its first result can be taken
// a line end or end of text pushes up to five results, which leave one a cycle while the
// result side is ready; the input register stalls while the eight-entry result queue has fewer than five free slots
// arst_n clears the line state, the queue pointers and limit_select; no clearing pass
// after a final report every further request is taken and gives nothing until reset
`timescale 1ns / 1ps

module basic_text_to_image_packer_core (
	input  logic                    clk,
	input  logic                    arst_n,
	bttip_text_if.sink              text,
	bttip_result_if.source          result,
	input  logic                    cfg_wen,
	input  logic                    cfg_wdata
);

	// input register
	logic                 in_valid_s1;
	logic [7:0]           text_byte_s1;
	logic                 end_of_text_s1;
	logic                 take;

	// line state and configuration
	bttip_pkg::state_t    st_q;
	bttip_pkg::state_t    st_nxt;
	logic                 limit_select_q;

	// burst from the step logic
	bttip_pkg::result_t                 burst [bttip_pkg::MAX_RESULTS];
	logic [bttip_pkg::RES_COUNT_W-1:0]  burst_count;
	logic [bttip_pkg::RES_COUNT_W-1:0]  push_count;

	// queue side
	bttip_pkg::result_t   head;
	logic                 head_valid;
	bttip_pkg::rq_stat_t  rq_stat;
	logic                 pop;

	// the held request is consumed once the queue can absorb a whole burst
	assign take       = in_valid_s1 && rq_stat.has_space;
	assign text.ready = !in_valid_s1 || take;
	assign push_count = take ? burst_count : '0;
	assign pop        = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (text.ready) begin
			in_valid_s1 <= text.valid;
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			text_byte_s1   <= text.text_byte;
			end_of_text_s1 <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase              <= bttip_pkg::PH_START;
			st_q.line_number        <= '0;
			st_q.nonzero_digit_seen <= 1'b0;
			st_q.body_length        <= '0;
			st_q.record_base        <= '0;
			st_q.line_count         <= '0;
		end else if (take) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_select_q <= 1'b0;
		end else if (cfg_wen) begin
			limit_select_q <= cfg_wdata;
		end
	end

	// decode of one character, header writes and final report
	bttip_step u_step (
		.st           (st_q),
		.limit_select (limit_select_q),
		.text_byte    (text_byte_s1),
		.end_of_text  (end_of_text_s1),
		.nxt          (st_nxt),
		.res          (burst),
		.res_count    (burst_count)
	);

	// results wait here until the far side takes them
	bttip_rq u_rq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (burst),
		.push_count (push_count),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.stat       (rq_stat)
	);

	assign result.valid         = head_valid;
	assign result.write_valid   = head.write_valid;
	assign result.write_address = head.write_address;
	assign result.write_data    = head.write_data;
	assign result.done_res      = head.done_res;
	assign result.status        = head.status;
	assign result.image_size    = head.image_size;
	assign result.last_result   = head.last_result;

`ifndef ASSERT_OFF
	// the report always closes the burst of its request
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.done_res |-> result.last_result)
		else $error("report result not marked last");

	// a halted block never pushes results
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == bttip_pkg::PH_HALT |-> push_count == '0)
		else $error("results pushed after final report");

	// the space check keeps the queue from overflowing
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_stat.fill <= bttip_pkg::FILL_W'(bttip_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	// a taken report leaves the block halted
	a_report_halts: assert property (@(posedge clk) disable iff (!arst_n)
		pop && result.done_res |-> st_q.phase == bttip_pkg::PH_HALT)
		else $error("report delivered while not halted");
`endif

endmodule

FILE: tb/tb_basic_text_to_image_packer_core.sv
// tb_basic_text_to_image_packer_core: self-checking testbench of the text to image packer
// depends on bttip_pkg, bttip_if and basic_text_to_image_packer_core; needs nothing else
// line text goes in on the text channel, predicted image writes are checked as they leave
`timescale 1ns / 1ps

module tb_basic_text_to_image_packer_core;

	// run limits: a few hundred requests, bursts of up to five results, long hold-offs
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_SLACK = 6;
	localparam int END_SLACK   = 20;
	localparam int IDLE_PCT    = 19;
	localparam int HOLD_OFF    = 300;

	// how the text stream is brought to its one and only final report
	typedef enum int {
		END_AT_LINE_START,
		END_OPEN_BODY,
		END_OPEN_NUMBER,
		END_ZERO_NUMBER,
		END_NON_DIGIT,
		END_ZERO_AT_SPACE,
		END_TOO_LONG
	} ending_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic cfg_wdata;

	bttip_text_if   text_ch();
	bttip_result_if result_ch();

	basic_text_to_image_packer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text_ch),
		.result    (result_ch),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// packer state as the predictor sees it
	bttip_pkg::phase_t img_phase;
	logic [15:0]       img_number;
	bit                img_nonzero;
	logic [7:0]        img_body_len;
	int unsigned       img_base;
	int unsigned       img_line_len;
	bit                img_limit_sel;

	bttip_pkg::result_t step_writes[$];   // results of the request being predicted
	bttip_pkg::result_t writes_due[$];    // image writes and reports still to come out

	int  mismatches   = 0;
	int  results_seen = 0;
	int  cycle_count  = 0;
	int  hold_cycles  = 0;
	int  hold_req     = 0;
	int  hold_seen    = 0;
	bit  src_idle;
	bit  sink_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void reset_packer_model();
		img_phase     = bttip_pkg::PH_START;
		img_number    = '0;
		img_nonzero   = 1'b0;
		img_body_len  = '0;
		img_base      = 0;
		img_line_len  = 0;
		img_limit_sel = 1'b0;
	endfunction

	function automatic int unsigned image_limit();
		return img_limit_sel ? bttip_pkg::IMAGE_MAX : bttip_pkg::LIMIT_SMALL;
	endfunction

	// a write at or above the image limit simply vanishes
	function automatic void emit_write(int unsigned addr, logic [7:0] data);
		bttip_pkg::result_t r;
		if (addr >= image_limit())
			return;
		r = '0;
		r.write_valid   = 1'b1;
		r.write_address = addr[bttip_pkg::ADDR_W-1:0];
		r.write_data    = data;
		step_writes.push_back(r);
	endfunction

	// the report rides on the last write of the request, or stands alone
	function automatic void add_report(logic [1:0] st);
		bttip_pkg::result_t r;
		if (step_writes.size() == 0)
			r = '0;
		else
			r = step_writes.pop_back();
		r.done_res   = 1'b1;
		r.status     = st;
		r.image_size = img_base[bttip_pkg::BASE_W-1:0];
		step_writes.push_back(r);
		img_phase = bttip_pkg::PH_HALT;
	endfunction

	// header at the record base, terminator after the body, pad zero for odd bodies
	function automatic void close_record();
		int unsigned len;
		int unsigned pad;
		int unsigned nxt;
		len = img_body_len;
		pad = len & 1;
		emit_write(img_base, img_number[7:0]);
		emit_write(img_base + 1, img_number[15:8]);
		emit_write(img_base + 2, 8'(len + pad));
		emit_write(img_base + 3 + len, 8'h00);
		if (pad != 0)
			emit_write(img_base + 4 + len, 8'h00);
		nxt = img_base + 4 + len + pad;
		img_base = (nxt > bttip_pkg::SIZE_SAT) ? bttip_pkg::SIZE_SAT : nxt;
		img_phase = bttip_pkg::PH_START;
	endfunction

	function automatic void pack_text_request(logic [7:0] c, logic eot);
		bit                 eol;
		bit                 digit;
		int unsigned        nxt;
		bttip_pkg::result_t r;
		eol   = (c == bttip_pkg::CH_CR) || (c == bttip_pkg::CH_LF);
		digit = (c >= bttip_pkg::CH_ZERO) && (c <= bttip_pkg::CH_NINE);
		step_writes.delete();
		if (img_phase == bttip_pkg::PH_HALT)
			return;
		if (eot) begin
			// open line is closed first, then the size report
			if (img_phase == bttip_pkg::PH_NUMBER && !img_nonzero) begin
				add_report(bttip_pkg::ST_BAD_NUMBER);
			end else begin
				if (img_phase != bttip_pkg::PH_START)
					close_record();
				add_report(img_base > image_limit() ? bttip_pkg::ST_OVER_LIMIT
					: bttip_pkg::ST_OK);
			end
		end else if (img_phase == bttip_pkg::PH_START) begin
			// empty lines give nothing, so cr lf ends a line once
			if (!eol) begin
				if (!digit) begin
					add_report(bttip_pkg::ST_BAD_NUMBER);
				end else begin
					img_number   = {8'd0, c - bttip_pkg::CH_ZERO};
					img_nonzero  = (c != bttip_pkg::CH_ZERO);
					img_line_len = 1;
					img_body_len = '0;
					img_phase    = bttip_pkg::PH_NUMBER;
				end
			end
		end else if (eol) begin
			if (img_phase == bttip_pkg::PH_NUMBER && !img_nonzero)
				add_report(bttip_pkg::ST_BAD_NUMBER);
			else
				close_record();
		end else if (img_line_len >= bttip_pkg::MAX_LINE - 1) begin
			add_report(bttip_pkg::ST_TOO_LONG);
		end else begin
			img_line_len++;
			case (img_phase)
				bttip_pkg::PH_NUMBER: begin
					if (digit) begin
						nxt = img_number * 10 + (c - bttip_pkg::CH_ZERO);
						img_number = nxt[15:0];
						if (c != bttip_pkg::CH_ZERO)
							img_nonzero = 1'b1;
					end else if (!img_nonzero) begin
						add_report(bttip_pkg::ST_BAD_NUMBER);
					end else begin
						img_phase = (c == bttip_pkg::CH_SPACE) ? bttip_pkg::PH_BODY
							: bttip_pkg::PH_SKIP;
					end
				end
				bttip_pkg::PH_SKIP: begin
					if (c == bttip_pkg::CH_SPACE)
						img_phase = bttip_pkg::PH_BODY;
				end
				default: begin
					emit_write(img_base + 3 + img_body_len, c);
					img_body_len = img_body_len + 8'd1;
				end
			endcase
		end
		if (step_writes.size() != 0) begin
			r = step_writes.pop_back();
			r.last_result = 1'b1;
			step_writes.push_back(r);
		end
		foreach (step_writes[i])
			writes_due.push_back(step_writes[i]);
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t: result %0d %s: got %0h, want %0h", $realtime, results_seen,
			what, got, want);
		mismatches++;
	endtask

	// each accepted result against the oldest expectation, field by field
	always @(posedge clk) begin : check_results
		bttip_pkg::result_t got;
		bttip_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.write_valid   = result_ch.write_valid;
			got.write_address = result_ch.write_address;
			got.write_data    = result_ch.write_data;
			got.done_res      = result_ch.done_res;
			got.status        = result_ch.status;
			got.image_size    = result_ch.image_size;
			got.last_result   = result_ch.last_result;
			if (writes_due.size() == 0) begin
				note_mismatch("with nothing expected", 32'(got), 0);
			end else begin
				want = writes_due.pop_front();
				if (got.write_valid !== want.write_valid)
					note_mismatch("write_valid", 32'(got.write_valid),
						32'(want.write_valid));
				if (got.write_address !== want.write_address)
					note_mismatch("write_address", 32'(got.write_address),
						32'(want.write_address));
				if (got.write_data !== want.write_data)
					note_mismatch("write_data", 32'(got.write_data), 32'(want.write_data));
				if (got.done_res !== want.done_res)
					note_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
				if (got.status !== want.status)
					note_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.image_size !== want.image_size)
					note_mismatch("image_size", 32'(got.image_size), 32'(want.image_size));
				if (got.last_result !== want.last_result)
					note_mismatch("last_result", 32'(got.last_result),
						32'(want.last_result));
			end
			results_seen++;
		end
	end

	// result side: random stalls, or a counted hold-off when one is asked for
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cycles = HOLD_OFF - 1;
			result_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			result_ch.ready <= 1'b0;
			hold_cycles--;
		end else begin
			result_ch.ready <= !(sink_idle && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic send_char(input logic [7:0] c, input logic eot);
		while (src_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid       <= 1'b1;
		text_ch.text_byte   <= c;
		text_ch.end_of_text <= eot;
		do
			@(posedge clk);
		while (!text_ch.ready);
		pack_text_request(c, eot);
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	// any byte that does not end a line
	function automatic logic [7:0] body_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == bttip_pkg::CH_CR || b == bttip_pkg::CH_LF);
		return b;
	endfunction

	// a byte that moves the number into the skip phase
	function automatic logic [7:0] junk_char();
		logic [7:0] b;
		do
			b = body_char();
		while (b == bttip_pkg::CH_SPACE ||
			(b >= bttip_pkg::CH_ZERO && b <= bttip_pkg::CH_NINE));
		return b;
	endfunction

	// lowers valid, then waits for every expected result and a little beyond
	task automatic wait_until_drained();
		text_ch.valid <= 1'b0;
		while (writes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	// limit_select only changes while nothing is in flight
	task automatic write_limit(input bit sel);
		wait_until_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= sel;
		@(negedge clk);
		cfg_wen <= 1'b0;
		img_limit_sel = sel;
	endtask

	// a well-formed line with random number, optional skipped bytes, optional random body
	task automatic send_random_line();
		int         digits;
		int         shape;
		int         body_len;
		int         i;
		bit         nonzero;
		logic [7:0] b;
		shape  = $urandom_range(0, 99);
		digits = $urandom_range(1, 5);
		nonzero = 1'b0;
		if ($urandom_range(0, 9) == 0)
			send_char($urandom_range(0, 1) ? bttip_pkg::CH_CR : bttip_pkg::CH_LF, 1'b0);
		for (i = 0; i < digits; i++) begin
			// number never all zeros here, that would stop the block
			if (i == digits - 1 && !nonzero)
				b = 8'(bttip_pkg::CH_ZERO + $urandom_range(1, 9));
			else
				b = 8'(bttip_pkg::CH_ZERO + $urandom_range(0, 9));
			if (b != bttip_pkg::CH_ZERO)
				nonzero = 1'b1;
			send_char(b, 1'b0);
		end
		if (shape >= 10) begin
			if (shape < 35) begin
				send_char(junk_char(), 1'b0);
				repeat ($urandom_range(0, 2)) send_char(junk_char(), 1'b0);
			end
			// shapes 20..34 leave the line with no space at all
			if (shape < 20 || shape >= 35) begin
				send_char(bttip_pkg::CH_SPACE, 1'b0);
				body_len = $urandom_range(0, 12);
				for (i = 0; i < body_len; i++)
					send_char(body_char(), 1'b0);
			end
		end
		case ($urandom_range(0, 3))
			0: send_char(bttip_pkg::CH_CR, 1'b0);
			1: send_char(bttip_pkg::CH_LF, 1'b0);
			2: begin
				send_char(bttip_pkg::CH_CR, 1'b0);
				send_char(bttip_pkg::CH_LF, 1'b0);
			end
			default: begin
				send_char(bttip_pkg::CH_LF, 1'b0);
				send_char(bttip_pkg::CH_LF, 1'b0);
			end
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// field extremes and the odd corners of line parsing
	task automatic test_directed_lines();
		send_char(bttip_pkg::CH_LF, 1'b0);   // empty line
		send_str("9 ");                      // odd body with nul, all-ones, cr lf
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(bttip_pkg::CH_CR, 1'b0);
		send_char(bttip_pkg::CH_LF, 1'b0);
		send_str("65535");                   // largest number, no space
		send_char(bttip_pkg::CH_LF, 1'b0);
		send_str("70000Q!");                 // wraps, skipped bytes with no space
		send_char(bttip_pkg::CH_CR, 1'b0);
		send_str("04x AB");                  // leading zero, skip then even body
		send_char(bttip_pkg::CH_LF, 1'b0);
	endtask

	task automatic test_random_lines(input int n_lines);
		repeat (n_lines) send_random_line();
	endtask

	// hold the result side off while requests keep coming, then pause to drain
	task automatic test_back_pressure();
		int i;
		src_idle = 1'b0;
		hold_req++;
		for (i = 0; i < 12; i++) begin
			send_char(8'(bttip_pkg::CH_ZERO + 1 + (i % 9)), 1'b0);
			if (i % 2 == 1) begin
				send_char(bttip_pkg::CH_SPACE, 1'b0);
				send_char(body_char(), 1'b0);
			end
			send_char(bttip_pkg::CH_LF, 1'b0);
		end
		src_idle = 1'b1;
		wait_until_drained();
	endtask

	// back-to-back requests with the result side always ready
	task automatic test_steady_stream();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		test_random_lines(6);
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// one way of stopping the block, chosen by the seed, then requests it must ignore
	task automatic test_final_report();
		ending_t how;
		int      i;
		write_limit(1'($urandom_range(0, 1)));
		how = ending_t'($urandom_range(0, 6));
		case (how)
			END_AT_LINE_START: begin
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			END_OPEN_BODY: begin
				send_char(8'(bttip_pkg::CH_ZERO + 3), 1'b0);
				if ($urandom_range(0, 1)) begin
					send_char(junk_char(), 1'b0);
				end else begin
					send_char(bttip_pkg::CH_SPACE, 1'b0);
					repeat ($urandom_range(1, 5)) send_char(body_char(), 1'b0);
				end
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			END_OPEN_NUMBER: begin
				send_str("42");
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			END_ZERO_NUMBER: begin
				if ($urandom_range(0, 1)) begin
					send_str("0");
					send_char(8'($urandom_range(0, 255)), 1'b1);
				end else begin
					send_str("00");
					send_char(bttip_pkg::CH_LF, 1'b0);
				end
			end
			END_NON_DIGIT: begin
				send_char(junk_char(), 1'b0);
			end
			END_ZERO_AT_SPACE: begin
				send_str("00 A");
			end
			default: begin
				send_str("1 ");
				for (i = 0; i < bttip_pkg::MAX_LINE + 4; i++)
					send_char(body_char(), 1'b0);
			end
		endcase
		// stopped block takes these and stays silent
		for (i = 0; i < 8; i++)
			send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n              = 1'b0;
		text_ch.valid       = 1'b0;
		text_ch.text_byte   = '0;
		text_ch.end_of_text = 1'b0;
		cfg_wen             = 1'b0;
		cfg_wdata           = 1'b0;
		src_idle            = 1'b1;
		sink_idle           = 1'b1;
		reset_packer_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_lines();
		write_limit(1'b1);
		test_random_lines(8);
		test_back_pressure();
		write_limit(1'b0);
		test_random_lines(6);
		test_steady_stream();
		test_final_report();

		wait_until_drained();
		repeat (END_SLACK) @(negedge clk);
		if (writes_due.size() != 0)
			note_mismatch("left over at end", 32'(writes_due.size()), 0);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
